@@ hw/rtl/ipa_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// ipa_pkg
// Types, codes and constants shared by the index pool allocator modules.
// -----------------------------------------------------------------------------
package ipa_pkg;

    localparam int DEFAULT_POOL_DEPTH = 64;
    localparam logic [6:0] BLOCK_COUNT_RST = 7'd64;
    localparam int LIST_CAP = 64;

    typedef enum logic [1:0] {
        CMD_ALLOC = 2'd0,
        CMD_FREE  = 2'd1,
        CMD_CHECK = 2'd2,
        CMD_LIST  = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        STAT_OK        = 2'd0,
        STAT_EXHAUSTED = 2'd1,
        STAT_INVALID   = 2'd2,
        STAT_EMPTY     = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_EXEC,
        ST_SWAP_A,
        ST_SWAP_B,
        ST_LIST
    } t_state;

    typedef struct packed {
        logic [1:0] command;
        logic [5:0] block_index;
        logic [6:0] list_limit;
    } t_req;

    typedef struct packed {
        logic [1:0] status;
        logic [5:0] result_index;
        logic [6:0] used_count;
        logic       last;
    } t_rsp;

    // controller to datapath
    typedef struct packed {
        logic accept;
        logic exec;
        logic swap_a;
        logic swap_b;
        logic list_step;
        logic clr_step;
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        t_cmd cmd;
        logic free_ok;
        logic more;
        logic clr_done;
    } t_dp_stat;

endpackage
`default_nettype wire

@@ hw/rtl/ipa_ctrl.sv @@
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// ipa_ctrl
// Sequencer: table clearing pass, command execution, free swap and list walk.
// -----------------------------------------------------------------------------
module ipa_ctrl (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              start,
    input  wire logic              i_cfg_we,
    input  wire ipa_pkg::t_dp_stat i_stat,
    output ipa_pkg::t_dp_cmd       o_cmd,
    output logic                   busy
);

    ipa_pkg::t_state r_state;
    ipa_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ipa_pkg::ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        busy    = 1'b1;
        case (r_state)
            ipa_pkg::ST_CLEAR: begin
                o_cmd.clr_step = 1'b1;
                if (i_cfg_we) begin
                    n_state = ipa_pkg::ST_CLEAR;
                end else if (i_stat.clr_done) begin
                    n_state = ipa_pkg::ST_IDLE;
                end
            end
            ipa_pkg::ST_IDLE: begin
                busy = 1'b0;
                if (i_cfg_we) begin
                    n_state = ipa_pkg::ST_CLEAR;
                end else if (start) begin
                    o_cmd.accept = 1'b1;
                    n_state      = ipa_pkg::ST_EXEC;
                end
            end
            ipa_pkg::ST_EXEC: begin
                o_cmd.exec = 1'b1;
                if (i_stat.cmd == ipa_pkg::CMD_FREE && i_stat.free_ok) begin
                    n_state = ipa_pkg::ST_SWAP_A;
                end else if (i_stat.cmd == ipa_pkg::CMD_LIST && i_stat.more) begin
                    n_state = ipa_pkg::ST_LIST;
                end else begin
                    n_state = ipa_pkg::ST_IDLE;
                end
            end
            ipa_pkg::ST_SWAP_A: begin
                o_cmd.swap_a = 1'b1;
                n_state      = ipa_pkg::ST_SWAP_B;
            end
            ipa_pkg::ST_SWAP_B: begin
                o_cmd.swap_b = 1'b1;
                n_state      = ipa_pkg::ST_IDLE;
            end
            ipa_pkg::ST_LIST: begin
                o_cmd.list_step = 1'b1;
                if (!i_stat.more) begin
                    n_state = ipa_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = ipa_pkg::ST_CLEAR;
            end
        endcase
    end

endmodule
`default_nettype wire

@@ hw/rtl/ipa_datapath.sv @@
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// ipa_datapath
// Order and position tables, allocated count, decisions and result register.
// -----------------------------------------------------------------------------
module ipa_datapath #(
    parameter int POOL_DEPTH = ipa_pkg::DEFAULT_POOL_DEPTH
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_cfg_we,
    input  wire logic [6:0]       i_cfg_data,
    input  wire ipa_pkg::t_req    i_req,
    input  wire ipa_pkg::t_dp_cmd i_cmd,
    output ipa_pkg::t_dp_stat     o_stat,
    output logic                  o_result_valid,
    output ipa_pkg::t_rsp         o_result
);

    localparam int IW = $clog2(POOL_DEPTH);
    localparam int CW = $clog2(POOL_DEPTH + 1);
    localparam int XW = (CW > 7) ? CW : 7;

    function automatic logic [XW-1:0] f_sat(input logic [6:0] bc);
        logic [XW-1:0] x;
        x = XW'(bc);
        if (x == '0) begin
            return XW'(1);
        end else if (x > XW'(POOL_DEPTH)) begin
            return XW'(POOL_DEPTH);
        end
        return x;
    endfunction

    logic [IW-1:0] r_order_mem [POOL_DEPTH];
    logic [IW-1:0] r_pos_mem   [POOL_DEPTH];

    logic [CW-1:0]   r_count;
    logic [XW-1:0]   r_eff;
    logic [IW-1:0]   r_clr;
    ipa_pkg::t_cmd   r_cmd;
    logic [IW-1:0]   r_idx;
    logic            r_idx_ok;
    logic [CW-1:0]   r_n;
    logic [CW-1:0]   r_lix;
    logic [IW-1:0]   r_ord_q;
    logic [IW-1:0]   r_pos_q;
    logic [IW-1:0]   r_slot;
    logic [IW-1:0]   r_other;
    logic            r_out_valid;
    ipa_pkg::t_rsp   r_out;

    logic [CW-1:0]   n_count;
    logic            n_out_valid;
    ipa_pkg::t_rsp   n_out;

    logic [XW-1:0]   count_x;
    logic [XW-1:0]   idx_x;
    logic [XW-1:0]   lim_x;
    logic [XW-1:0]   list_n;
    logic [CW-1:0]   cnt_m1;
    logic [CW-1:0]   lix_p1;
    logic [XW-1:0]   ord_x;
    logic            allocated;
    logic            full;
    logic            more;

    logic            ord_we;
    logic [IW-1:0]   ord_wa;
    logic [IW-1:0]   ord_wd;
    logic [IW-1:0]   ord_ra;
    logic            pos_we;
    logic [IW-1:0]   pos_wa;
    logic [IW-1:0]   pos_wd;
    logic [IW-1:0]   pos_ra;

    always_comb begin
        count_x   = XW'(r_count);
        idx_x     = XW'(i_req.block_index);
        lim_x     = XW'(i_req.list_limit);
        list_n    = (count_x < lim_x) ? count_x : lim_x;
        if (list_n > XW'(ipa_pkg::LIST_CAP)) begin
            list_n = XW'(ipa_pkg::LIST_CAP);
        end
        cnt_m1    = r_count - CW'(1);
        lix_p1    = r_lix + CW'(1);
        ord_x     = XW'(r_ord_q);
        allocated = r_idx_ok && (XW'(r_pos_q) < count_x);
        full      = count_x >= r_eff;
        more      = (r_n != '0) && (lix_p1 != r_n);
    end

    assign o_stat.cmd      = r_cmd;
    assign o_stat.free_ok  = allocated;
    assign o_stat.more     = more;
    assign o_stat.clr_done = (r_clr == IW'(POOL_DEPTH - 1));

    // table ports
    always_comb begin
        ord_we = 1'b0;
        ord_wa = r_clr;
        ord_wd = r_clr;
        pos_we = 1'b0;
        pos_wa = r_clr;
        pos_wd = r_clr;
        if (i_cmd.clr_step) begin
            ord_we = 1'b1;
            pos_we = 1'b1;
        end else if (i_cmd.swap_a) begin
            // move the last allocated block into the freed slot
            ord_we = 1'b1;
            ord_wa = r_slot;
            ord_wd = r_other;
            pos_we = 1'b1;
            pos_wa = r_other;
            pos_wd = r_slot;
        end else if (i_cmd.swap_b) begin
            ord_we = 1'b1;
            ord_wa = cnt_m1[IW-1:0];
            ord_wd = r_idx;
            pos_we = 1'b1;
            pos_wa = r_idx;
            pos_wd = cnt_m1[IW-1:0];
        end

        if (i_cmd.exec || i_cmd.list_step) begin
            ord_ra = lix_p1[IW-1:0];
        end else begin
            case (ipa_pkg::t_cmd'(i_req.command))
                ipa_pkg::CMD_ALLOC: ord_ra = r_count[IW-1:0];
                ipa_pkg::CMD_FREE:  ord_ra = cnt_m1[IW-1:0];
                default:            ord_ra = '0;
            endcase
        end
        pos_ra = idx_x[IW-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (ord_we) begin
            r_order_mem[ord_wa] <= ord_wd;
        end
        r_ord_q <= r_order_mem[ord_ra];
    end

    always_ff @(posedge i_clk) begin
        if (pos_we) begin
            r_pos_mem[pos_wa] <= pos_wd;
        end
        r_pos_q <= r_pos_mem[pos_ra];
    end

    // decisions and result
    always_comb begin
        n_count     = r_count;
        n_out_valid = 1'b0;
        n_out       = '0;
        if (i_cmd.exec) begin
            case (r_cmd)
                ipa_pkg::CMD_ALLOC: begin
                    n_out_valid = 1'b1;
                    if (full) begin
                        n_out.status = ipa_pkg::STAT_EXHAUSTED;
                    end else begin
                        n_out.status       = ipa_pkg::STAT_OK;
                        n_out.result_index = ord_x[5:0];
                        n_count            = r_count + CW'(1);
                    end
                end
                ipa_pkg::CMD_FREE: begin
                    // a good free reports after the swap
                    if (!allocated) begin
                        n_out_valid  = 1'b1;
                        n_out.status = ipa_pkg::STAT_INVALID;
                    end
                end
                ipa_pkg::CMD_CHECK: begin
                    n_out_valid  = 1'b1;
                    n_out.status = allocated ? ipa_pkg::STAT_OK : ipa_pkg::STAT_INVALID;
                end
                default: begin
                    n_out_valid = 1'b1;
                    if (r_n == '0) begin
                        n_out.status = ipa_pkg::STAT_EMPTY;
                    end else begin
                        n_out.status       = ipa_pkg::STAT_OK;
                        n_out.result_index = ord_x[5:0];
                    end
                end
            endcase
        end else if (i_cmd.list_step) begin
            n_out_valid        = 1'b1;
            n_out.status       = ipa_pkg::STAT_OK;
            n_out.result_index = ord_x[5:0];
        end else if (i_cmd.swap_b) begin
            n_out_valid  = 1'b1;
            n_out.status = ipa_pkg::STAT_OK;
            n_count      = cnt_m1;
        end
        n_out.used_count = 7'(XW'(n_count));
        n_out.last       = !more || (r_cmd != ipa_pkg::CMD_LIST);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_eff       <= f_sat(ipa_pkg::BLOCK_COUNT_RST);
            r_clr       <= '0;
            r_out_valid <= 1'b0;
            r_cmd       <= ipa_pkg::CMD_ALLOC;
            r_lix       <= '0;
            r_n         <= '0;
        end else begin
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                r_eff   <= f_sat(i_cfg_data);
                r_count <= '0;
                r_clr   <= '0;
            end else begin
                r_count <= n_count;
                if (i_cmd.clr_step) begin
                    r_clr <= r_clr + IW'(1);
                end
            end
            if (i_cmd.accept) begin
                r_cmd <= ipa_pkg::t_cmd'(i_req.command);
                r_lix <= '0;
                r_n   <= list_n[CW-1:0];
            end else if (i_cmd.list_step || (i_cmd.exec && r_cmd == ipa_pkg::CMD_LIST)) begin
                r_lix <= lix_p1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
        if (i_cmd.accept) begin
            r_idx    <= idx_x[IW-1:0];
            r_idx_ok <= idx_x < r_eff;
        end
        if (i_cmd.exec) begin
            r_slot  <= r_pos_q;
            r_other <= r_ord_q;
        end
    end

    assign o_result_valid = r_out_valid;
    assign o_result       = r_out;

endmodule
`default_nettype wire

@@ hw/rtl/index_pool_allocator.sv @@
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// index_pool_allocator
// Fixed pool of block indices with alloc, free, check and list commands.
// Alloc, check and failed free pass through accept and table read; the
// result strobes in the cycle after the read cycle. A good free adds the
// swap writes (SWAP_A, then SWAP_B) through each table's one write port.
// A list of n >= 1 indices strobes one result per index, the last flagged,
// and an empty list one EMPTY result. After reset or a block_count write in
// idle or clear, a clearing pass restores both tables to identity while busy
// stays high. Results are strobed for one cycle; the receiver cannot stall.
// -----------------------------------------------------------------------------
module index_pool_allocator #(
    parameter int POOL_DEPTH = ipa_pkg::DEFAULT_POOL_DEPTH
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          start,
    output logic               busy,
    input  wire ipa_pkg::t_req i_req,
    input  wire logic          i_cfg_we,
    input  wire logic [6:0]    i_cfg_data,
    output logic               o_result_valid,
    output ipa_pkg::t_rsp      o_result
);

    ipa_pkg::t_dp_cmd  dp_cmd;
    ipa_pkg::t_dp_stat dp_stat;

    ipa_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .i_cfg_we(i_cfg_we),
        .i_stat  (dp_stat),
        .o_cmd   (dp_cmd),
        .busy    (busy)
    );

    ipa_datapath #(
        .POOL_DEPTH(POOL_DEPTH)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_data    (i_cfg_data),
        .i_req         (i_req),
        .i_cmd         (dp_cmd),
        .o_stat        (dp_stat),
        .o_result_valid(o_result_valid),
        .o_result      (o_result)
    );

endmodule
`default_nettype wire

@@ sim/testbench.sv @@
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// testbench
// Self-checking bench for index_pool_allocator. Commands go in through the
// start/busy handshake. A mirror of both tables and the allocated count
// predicts every strobed result, and each result is checked field by field.
// The run covers several block_count settings, the extremes among them.
// -----------------------------------------------------------------------------
module testbench;
    import ipa_pkg::*;

    localparam int POOL = DEFAULT_POOL_DEPTH;
    localparam int QUIET_LIMIT = 2000;

    // Mirror of the pool: predicts the results of each accepted command and
    // checks the strobed results against them in order.
    class allocator_mirror;
        logic [5:0]  order_tbl [POOL];
        logic [5:0]  slot_of [POOL];
        int unsigned used;
        logic [6:0]  block_count;
        t_rsp        owed [$];
        int unsigned errors;

        function new();
            block_count = BLOCK_COUNT_RST;
            errors = 0;
            reinit();
        endfunction

        function void reinit();
            for (int i = 0; i < POOL; i++) begin
                order_tbl[i] = i[5:0];
                slot_of[i] = i[5:0];
            end
            used = 0;
        endfunction

        function void configure(logic [6:0] value);
            block_count = value;
            reinit();
        endfunction

        function int unsigned usable();
            if (block_count == 0) return 1;
            if (block_count > POOL) return POOL;
            return block_count;
        endfunction

        function bit holds(logic [5:0] idx);
            return (idx < usable()) && (slot_of[idx] < used);
        endfunction

        function void owe(t_status status, logic [5:0] idx, bit last);
            t_rsp r;
            r.status = status;
            r.result_index = idx;
            r.used_count = used[6:0];
            r.last = last;
            owed.push_back(r);
        endfunction

        function logic [5:0] pick_held();
            if (used == 0) return 6'($urandom_range(0, POOL - 1));
            return order_tbl[$urandom_range(0, used - 1)];
        endfunction

        function void note_request(t_req q);
            int unsigned n;
            int unsigned slot;
            int unsigned tail;
            logic [5:0]  other;
            case (t_cmd'(q.command))
                CMD_ALLOC: begin
                    if (used >= usable()) begin
                        owe(STAT_EXHAUSTED, '0, 1'b1);
                    end else begin
                        other = order_tbl[used];
                        used++;
                        owe(STAT_OK, other, 1'b1);
                    end
                end
                CMD_FREE: begin
                    if (used == 0 || !holds(q.block_index)) begin
                        owe(STAT_INVALID, '0, 1'b1);
                    end else begin
                        // swap with the last allocated block, then shrink
                        slot = slot_of[q.block_index];
                        tail = used - 1;
                        other = order_tbl[tail];
                        slot_of[other] = slot[5:0];
                        order_tbl[slot] = other;
                        slot_of[q.block_index] = tail[5:0];
                        order_tbl[tail] = q.block_index;
                        used = tail;
                        owe(STAT_OK, '0, 1'b1);
                    end
                end
                CMD_CHECK: begin
                    owe(holds(q.block_index) ? STAT_OK : STAT_INVALID, '0, 1'b1);
                end
                default: begin
                    n = used;
                    if (n > q.list_limit) n = q.list_limit;
                    if (n > LIST_CAP) n = LIST_CAP;
                    if (n == 0) begin
                        owe(STAT_EMPTY, '0, 1'b1);
                    end else begin
                        for (int i = 0; i < n; i++) owe(STAT_OK, order_tbl[i], i + 1 == n);
                    end
                end
            endcase
        endfunction

        function void check_response(t_rsp got);
            t_rsp want;
            if (owed.size() == 0) begin
                $error("result with nothing outstanding: status %0d index %0d",
                       got.status, got.result_index);
                errors++;
                return;
            end
            want = owed.pop_front();
            if (got.status !== want.status) begin
                $error("status mismatch: expected %0d, got %0d", want.status, got.status);
                errors++;
            end
            if (got.result_index !== want.result_index) begin
                $error("result_index mismatch: expected %0d, got %0d",
                       want.result_index, got.result_index);
                errors++;
            end
            if (got.used_count !== want.used_count) begin
                $error("used_count mismatch: expected %0d, got %0d",
                       want.used_count, got.used_count);
                errors++;
            end
            if (got.last !== want.last) begin
                $error("last mismatch: expected %0d, got %0d", want.last, got.last);
                errors++;
            end
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    t_req        req = '0;
    logic        i_cfg_we = 1'b0;
    logic [6:0]  i_cfg_data = '0;
    logic        o_result_valid;
    t_rsp        o_result;
    int unsigned quiet_cycles = 0;

    allocator_mirror mirror = new();

    index_pool_allocator dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_req          (req),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_data     (i_cfg_data),
        .o_result_valid (o_result_valid),
        .o_result       (o_result)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_result_valid === 1'b1) mirror.check_response(o_result);
    end

    // count cycles with no transfer on either side
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && busy === 1'b0) || o_result_valid === 1'b1) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        wait (quiet_cycles >= QUIET_LIMIT);
        $display("Simulation FAILED");
        $finish;
    end

    function automatic t_req make_req(t_cmd c, int idx, int lim);
        t_req r;
        r.command = c;
        r.block_index = idx[5:0];
        r.list_limit = lim[6:0];
        return r;
    endfunction

    // hold start until the command transfers
    task automatic issue(input t_req r);
        start <= 1'b1;
        req <= r;
        do @(posedge i_clk); while (busy !== 1'b0);
        mirror.note_request(r);
    endtask

    task automatic pause(input bit steady);
        int unsigned roll;
        int unsigned n;
        roll = $urandom_range(0, 99);
        if (steady || roll < 45) n = 0;
        else if (roll < 85) n = $urandom_range(1, 3);
        else if (roll < 95) n = $urandom_range(4, 10);
        else n = $urandom_range(11, 40);
        if (n > 0) begin
            start <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
    endtask

    // write only once every result is in and the pool is idle
    task automatic set_block_count(input logic [6:0] value);
        start <= 1'b0;
        do @(posedge i_clk); while (mirror.owed.size() != 0 || busy !== 1'b0);
        i_cfg_we <= 1'b1;
        i_cfg_data <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        mirror.configure(value);
        repeat (2) @(posedge i_clk);
    endtask

    task automatic send(input t_cmd c, input int idx, input int lim);
        issue(make_req(c, idx, lim));
        pause(1'b0);
    endtask

    task automatic directed_checks();
        send(CMD_LIST, 0, 5);
        send(CMD_CHECK, 0, 0);
        send(CMD_FREE, 63, 0);
        repeat (4) send(CMD_ALLOC, 0, 0);
        send(CMD_CHECK, 2, 0);
        send(CMD_CHECK, 63, 0);
        send(CMD_LIST, 0, 0);
        send(CMD_LIST, 0, 127);
        send(CMD_FREE, 1, 0);
        send(CMD_LIST, 0, 64);
        send(CMD_FREE, 1, 0);
        send(CMD_FREE, 0, 0);
        send(CMD_FREE, 2, 0);
        send(CMD_ALLOC, 0, 0);
        send(CMD_LIST, 0, 2);
        // single-block pool: exhaustion and out-of-range indices
        set_block_count(7'd1);
        send(CMD_ALLOC, 0, 0);
        send(CMD_ALLOC, 0, 0);
        send(CMD_CHECK, 1, 0);
        send(CMD_FREE, 1, 0);
        send(CMD_LIST, 0, 64);
        send(CMD_FREE, 0, 0);
        send(CMD_LIST, 0, 3);
    endtask

    // fill the pool for the first two thirds of the phase, then drain it
    task automatic random_phase(input int count);
        int unsigned roll;
        int unsigned pick;
        bit          filling;
        t_req        r;
        for (int i = 0; i < count; i++) begin
            filling = i < (count * 2) / 3;
            roll = $urandom_range(0, 99);
            r.block_index = 6'($urandom_range(0, POOL - 1));
            pick = $urandom_range(0, 99);
            if (pick < 70) r.list_limit = 7'($urandom_range(0, 8));
            else if (pick < 95) r.list_limit = 7'($urandom_range(0, 64));
            else r.list_limit = 7'($urandom_range(65, 127));
            if (roll < (filling ? 80 : 25)) begin
                r.command = CMD_ALLOC;
            end else if (roll < (filling ? 85 : 75)) begin
                r.command = CMD_FREE;
                if ($urandom_range(0, 9) < 8) r.block_index = mirror.pick_held();
            end else if (roll < (filling ? 93 : 88)) begin
                r.command = CMD_CHECK;
                if ($urandom_range(0, 1) == 1) r.block_index = mirror.pick_held();
            end else begin
                r.command = CMD_LIST;
            end
            issue(r);
            pause((i % 50) < 15);
        end
    endtask

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(posedge i_clk);

        directed_checks();
        set_block_count(7'd64);
        random_phase(60);
        set_block_count(7'd1);
        random_phase(40);
        set_block_count(7'd0);
        random_phase(40);
        set_block_count(7'd3);
        random_phase(60);
        set_block_count(7'd127);
        random_phase(130);
        set_block_count(7'($urandom_range(2, 63)));
        random_phase(60);
        set_block_count(7'd64);
        random_phase(110);

        start <= 1'b0;
        do @(posedge i_clk); while (mirror.owed.size() != 0);
        repeat (20) @(posedge i_clk);
        if (mirror.errors == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
